### rtl/fmh_pkg.sv
// shared types, constants and command/status structs of the four-ary min heap
package fmh_pkg;

  localparam int unsigned CAPACITY_DEF = 1024;
  localparam int unsigned WEIGHT_W     = 31;
  localparam int unsigned PAYLOAD_W    = 32;
  localparam int unsigned STATUS_W     = 2;
  localparam int unsigned COUNT_W      = 11;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_DONE  = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    logic [WEIGHT_W-1:0]  weight;
    logic [PAYLOAD_W-1:0] payload;
  } entry_t;

  typedef enum logic [1:0] {
    RD_ROOT,
    RD_LAST,
    RD_PARENT,
    RD_CHILD
  } rd_sel_e;

  typedef enum logic [1:0] {
    WR_CUR,
    WR_RD,
    WR_BEST
  } wr_sel_e;

  typedef struct packed {
    logic    take_req;
    status_e new_status;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    rd_en;
    rd_sel_e rd_sel;
    logic [1:0] child_k;
    logic    wr_en;
    wr_sel_e wr_sel;
    logic    idx_push;
    logic    idx_zero;
    logic    idx_parent;
    logic    idx_best;
    logic    res_load;
    logic    cur_load;
    logic    best_clr;
    logic    best_cmp;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic idx_zero;
    logic up_less;
    logic child_ok;
    logic down_move;
    logic out_free;
  } stat_t;

endpackage

### rtl/fmh_req_if.sv
// request channel: operation and entry to push
interface fmh_req_if;
  logic                           valid;
  logic                           ready;
  logic                           operation;
  logic [fmh_pkg::WEIGHT_W-1:0]   item_weight;
  logic [fmh_pkg::PAYLOAD_W-1:0]  item_payload;

  modport source (output valid, output operation, output item_weight, output item_payload,
                  input ready);
  modport sink   (input valid, input operation, input item_weight, input item_payload,
                  output ready);
endinterface

### rtl/fmh_rsp_if.sv
// response channel: popped entry, status and entry count
interface fmh_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [fmh_pkg::WEIGHT_W-1:0]   result_weight;
  logic [fmh_pkg::PAYLOAD_W-1:0]  result_payload;
  logic [fmh_pkg::STATUS_W-1:0]   status;
  logic [fmh_pkg::COUNT_W-1:0]    entry_count;

  modport source (output valid, output result_weight, output result_payload, output status,
                  output entry_count, input ready);
  modport sink   (input valid, input result_weight, input result_payload, input status,
                  input entry_count, output ready);
endinterface

### rtl/fmh_dp.sv
// heap datapath: entry memory, hole index, count, child minimum and result registers
module fmh_dp #(
  parameter int unsigned CAPACITY = fmh_pkg::CAPACITY_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  fmh_pkg::cmd_t                 cmd_i,
  output fmh_pkg::stat_t                stat_o,
  input  logic [fmh_pkg::WEIGHT_W-1:0]  req_weight_i,
  input  logic [fmh_pkg::PAYLOAD_W-1:0] req_payload_i,
  input  logic                          rsp_ready_i,
  output logic                          rsp_valid_o,
  output logic [fmh_pkg::WEIGHT_W-1:0]  rsp_weight_o,
  output logic [fmh_pkg::PAYLOAD_W-1:0] rsp_payload_o,
  output logic [fmh_pkg::STATUS_W-1:0]  rsp_status_o,
  output logic [fmh_pkg::COUNT_W-1:0]   rsp_count_o
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned XW = AW + 3;

  fmh_pkg::entry_t  mem_q [CAPACITY];
  fmh_pkg::entry_t  rd_data_q, cur_q, cur_d, best_q, res_q, wr_data;
  fmh_pkg::status_e status_q;
  logic [AW-1:0]    idx_q, idx_d, rd_idx_q, best_idx_q, parent, rd_addr;
  logic [XW-1:0]    child;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             best_vld_q, best_vld_d, best_take;
  logic             out_vld_q, out_vld_d;
  logic [fmh_pkg::WEIGHT_W-1:0]  out_weight_q;
  logic [fmh_pkg::PAYLOAD_W-1:0] out_payload_q;
  logic [fmh_pkg::STATUS_W-1:0]  out_status_q;
  logic [fmh_pkg::COUNT_W-1:0]   out_count_q;

  assign parent = (idx_q - AW'(1)) >> 2;
  assign child  = XW'({idx_q, 2'b00}) + XW'(cmd_i.child_k) + XW'(1);

  always_comb begin
    unique case (cmd_i.rd_sel)
      fmh_pkg::RD_ROOT:   rd_addr = '0;
      fmh_pkg::RD_LAST:   rd_addr = AW'(cnt_q);
      fmh_pkg::RD_PARENT: rd_addr = parent;
      fmh_pkg::RD_CHILD:  rd_addr = child[AW-1:0];
      default:            rd_addr = '0;
    endcase
  end

  always_comb begin
    unique case (cmd_i.wr_sel)
      fmh_pkg::WR_CUR:  wr_data = cur_q;
      fmh_pkg::WR_RD:   wr_data = rd_data_q;
      fmh_pkg::WR_BEST: wr_data = best_q;
      default:          wr_data = cur_q;
    endcase
  end

  // heap storage, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem_q[idx_q] <= wr_data;
    end
    if (cmd_i.rd_en) begin
      rd_data_q <= mem_q[rd_addr];
      rd_idx_q  <= rd_addr;
    end
  end

  assign best_take = cmd_i.best_cmp && (!best_vld_q || (rd_data_q.weight < best_q.weight));

  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.cnt_inc) begin
      cnt_d = cnt_q + CW'(1);
    end else if (cmd_i.cnt_dec) begin
      cnt_d = cnt_q - CW'(1);
    end

    idx_d = idx_q;
    if (cmd_i.idx_push) begin
      idx_d = AW'(cnt_q);
    end else if (cmd_i.idx_zero) begin
      idx_d = '0;
    end else if (cmd_i.idx_parent) begin
      idx_d = parent;
    end else if (cmd_i.idx_best) begin
      idx_d = best_idx_q;
    end

    cur_d = cur_q;
    if (cmd_i.take_req) begin
      cur_d = '{weight: req_weight_i, payload: req_payload_i};
    end else if (cmd_i.cur_load) begin
      cur_d = rd_data_q;
    end

    best_vld_d = best_vld_q;
    if (cmd_i.best_clr) begin
      best_vld_d = 1'b0;
    end else if (best_take) begin
      best_vld_d = 1'b1;
    end

    out_vld_d = out_vld_q;
    if (cmd_i.out_load) begin
      out_vld_d = 1'b1;
    end else if (rsp_ready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q      <= '0;
      best_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      cnt_q      <= cnt_d;
      best_vld_q <= best_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    cur_q <= cur_d;
    if (best_take) begin
      best_q     <= rd_data_q;
      best_idx_q <= rd_idx_q;
    end
    if (cmd_i.take_req) begin
      res_q    <= '0;
      status_q <= cmd_i.new_status;
    end else if (cmd_i.res_load) begin
      res_q    <= rd_data_q;
    end
    if (cmd_i.out_load) begin
      out_weight_q  <= res_q.weight;
      out_payload_q <= res_q.payload;
      out_status_q  <= status_q;
      out_count_q   <= fmh_pkg::COUNT_W'(cnt_q);
    end
  end

  assign stat_o.full      = (cnt_q == CW'(CAPACITY));
  assign stat_o.empty     = (cnt_q == '0);
  assign stat_o.idx_zero  = (idx_q == '0);
  assign stat_o.up_less   = (cur_q.weight < rd_data_q.weight);
  assign stat_o.child_ok  = (child < XW'(cnt_q));
  assign stat_o.down_move = best_vld_q && (best_q.weight < cur_q.weight);
  assign stat_o.out_free  = !out_vld_q || rsp_ready_i;

  assign rsp_valid_o   = out_vld_q;
  assign rsp_weight_o  = out_weight_q;
  assign rsp_payload_o = out_payload_q;
  assign rsp_status_o  = out_status_q;
  assign rsp_count_o   = out_count_q;

endmodule

### rtl/fmh_ctrl.sv
// heap controller: sequences push sift-up and pop sift-down over the datapath
module fmh_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           req_valid_i,
  input  logic           req_op_i,
  output logic           req_ready_o,
  input  fmh_pkg::stat_t stat_i,
  output fmh_pkg::cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_POP_ROOT,
    S_POP_LAST,
    S_UP_CHK,
    S_UP_CMP,
    S_DN,
    S_FIN
  } state_e;

  state_e     state_q, state_d;
  logic [1:0] k_q, k_d;
  logic       kdone_q, kdone_d;
  logic       pend_q, pend_d;
  logic       issue;

  assign req_ready_o = (state_q == S_IDLE);
  assign issue       = (state_q == S_DN) && !kdone_q && stat_i.child_ok;

  always_comb begin
    cmd_o            = '0;
    cmd_o.new_status = fmh_pkg::STATUS_DONE;
    cmd_o.rd_sel     = fmh_pkg::RD_ROOT;
    cmd_o.wr_sel     = fmh_pkg::WR_CUR;
    cmd_o.child_k    = k_q;
    state_d          = state_q;
    k_d              = k_q;
    kdone_d          = kdone_q;
    pend_d           = pend_q;

    unique case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          cmd_o.take_req = 1'b1;
          if (fmh_pkg::op_e'(req_op_i) == fmh_pkg::OP_POP) begin
            if (stat_i.empty) begin
              cmd_o.new_status = fmh_pkg::STATUS_EMPTY;
              state_d          = S_FIN;
            end else begin
              cmd_o.cnt_dec = 1'b1;
              cmd_o.rd_en   = 1'b1;
              cmd_o.rd_sel  = fmh_pkg::RD_ROOT;
              state_d       = S_POP_ROOT;
            end
          end else begin
            if (stat_i.full) begin
              cmd_o.new_status = fmh_pkg::STATUS_FULL;
              state_d          = S_FIN;
            end else begin
              cmd_o.cnt_inc  = 1'b1;
              cmd_o.idx_push = 1'b1;
              state_d        = S_UP_CHK;
            end
          end
        end
      end
      S_POP_ROOT: begin
        cmd_o.res_load = 1'b1;
        cmd_o.rd_en    = 1'b1;
        cmd_o.rd_sel   = fmh_pkg::RD_LAST;
        state_d        = S_POP_LAST;
      end
      S_POP_LAST: begin
        cmd_o.cur_load = 1'b1;
        cmd_o.idx_zero = 1'b1;
        cmd_o.best_clr = 1'b1;
        k_d            = '0;
        kdone_d        = 1'b0;
        pend_d         = 1'b0;
        state_d        = S_DN;
      end
      S_UP_CHK: begin
        if (stat_i.idx_zero) begin
          cmd_o.wr_en  = 1'b1;
          cmd_o.wr_sel = fmh_pkg::WR_CUR;
          state_d      = S_FIN;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = fmh_pkg::RD_PARENT;
          state_d      = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        cmd_o.wr_en = 1'b1;
        if (stat_i.up_less) begin
          cmd_o.wr_sel     = fmh_pkg::WR_RD;
          cmd_o.idx_parent = 1'b1;
          state_d          = S_UP_CHK;
        end else begin
          cmd_o.wr_sel = fmh_pkg::WR_CUR;
          state_d      = S_FIN;
        end
      end
      S_DN: begin
        // children are read one per cycle, each compared in the cycle after its read
        cmd_o.best_cmp = pend_q;
        pend_d         = issue;
        if (issue) begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = fmh_pkg::RD_CHILD;
          k_d          = k_q + 2'd1;
          kdone_d      = (k_q == 2'd3);
        end else if (!pend_q) begin
          cmd_o.wr_en = 1'b1;
          if (stat_i.down_move) begin
            cmd_o.wr_sel   = fmh_pkg::WR_BEST;
            cmd_o.idx_best = 1'b1;
            cmd_o.best_clr = 1'b1;
            k_d            = '0;
            kdone_d        = 1'b0;
          end else begin
            cmd_o.wr_sel = fmh_pkg::WR_CUR;
            state_d      = S_FIN;
          end
        end
      end
      S_FIN: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      k_q     <= '0;
      kdone_q <= 1'b0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      kdone_q <= kdone_d;
      pend_q  <= pend_d;
    end
  end

endmodule

### rtl/four_ary_min_heap.sv
// four-ary min heap priority queue, top level
//
// req_i takes one request per beat: operation 0 pushes (item_weight, item_payload),
// operation 1 pops the lightest entry. Every request gives exactly one beat on rsp_o
// with the popped entry (zero for a push or an error), a status (done, pop on empty,
// push on full) and the entry count after the request. Errors leave the heap as is.
// One request is worked at a time; req_i.ready is high while the sequencer is idle.
// The heap sits in a single memory with one write and one registered read per cycle,
// so every step below goes through that read port:
//   push: over L levels the parent is read, then moved down if the new entry is lighter,
//         L = levels the new entry climbs (0 .. log4 CAPACITY)
//   pop:  the root is read as the result and the last entry as the moving entry;
//         a level costs its child reads plus compare and write
//   errors: go straight to the result
// The result sits in an output register; the next request is taken while it waits,
// and a finished result holds in the sequencer until rsp_o is free again.
// Reset empties the heap at once (count to zero); storage needs no clearing pass.
module four_ary_min_heap #(
  parameter int unsigned CAPACITY = fmh_pkg::CAPACITY_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  fmh_req_if.sink   req_i,
  fmh_rsp_if.source rsp_o
);

  fmh_pkg::cmd_t  cmd;
  fmh_pkg::stat_t stat;

  fmh_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_op_i    (req_i.operation),
    .req_ready_o (req_i.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  fmh_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .req_weight_i  (req_i.item_weight),
    .req_payload_i (req_i.item_payload),
    .rsp_ready_i   (rsp_o.ready),
    .rsp_valid_o   (rsp_o.valid),
    .rsp_weight_o  (rsp_o.result_weight),
    .rsp_payload_o (rsp_o.result_payload),
    .rsp_status_o  (rsp_o.status),
    .rsp_count_o   (rsp_o.entry_count)
  );

endmodule
